### hdl/smoothed_frame_rate_meter_top_defines.svh
// assertion macros for the smoothed frame rate meter
// used by the datapath; needs clk and rst in the including module
`ifndef SMOOTHED_FRAME_RATE_METER_TOP_DEFINES_SVH
`define SMOOTHED_FRAME_RATE_METER_TOP_DEFINES_SVH

// same-cycle implication
`define SFRM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfrm assertion failed");

// next-cycle implication
`define SFRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfrm assertion failed");

`endif

### hdl/sfrm_pkg.sv
// shared types and constants of the smoothed frame rate meter
// no dependencies
package sfrm_pkg;

  localparam int unsigned STAMP_W = 64;
  localparam int unsigned RATE_W  = 48;
  localparam int unsigned SECS_W  = 33;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned NUM_W   = 49;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned OUT_W   = 152;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned ADDR_W  = 4;

  localparam logic [TICK_W-1:0] TICK_RATE_RESET    = 32'd1000;
  localparam logic [RATE_W-1:0] INITIAL_RATE_RESET = 48'd3932160;
  localparam logic [RATE_W-1:0] ONE_Q16            = 48'h0000_0001_0000;
  localparam logic [NUM_W-1:0]  RECIP_NUM          = {1'b1, {(NUM_W-1){1'b0}}};

  // register select, address bit 3
  localparam logic REG_TICK_RATE    = 1'b0;
  localparam logic REG_INITIAL_RATE = 1'b1;

  localparam logic MODE_START = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICKS_GO,
    ST_TICKS_WAIT,
    ST_INST_GO,
    ST_INST_WAIT,
    ST_RECIP_GO,
    ST_RECIP_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_TICKS,
    DIV_INST,
    DIV_RECIP
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     load_start;
    logic     store_delta;
    logic     div_go;
    div_sel_t div_sel;
    logic     store_ticks;
    logic     blend;
    logic     store_secs;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic same_stamp;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### hdl/sfrm_div.sv
// restoring divider, one quotient bit per cycle
// depends on sfrm_pkg
module sfrm_div
  import sfrm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [NUM_W-1:0]   num,
  input  logic [STAMP_W-1:0] den,
  output logic               busy,
  output logic               done,
  output logic [NUM_W-1:0]   quot
);

  logic [CNT_W-1:0]   cnt;
  logic [STAMP_W-1:0] rem;
  logic [STAMP_W-1:0] den_r;
  logic [STAMP_W:0]   shifted;
  logic [STAMP_W+1:0] diff;
  logic               fits;

  assign shifted = {rem, quot[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign fits    = !diff[STAMP_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (busy) begin
      rem  <= fits ? diff[STAMP_W-1:0] : shifted[STAMP_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

### hdl/sfrm_dp.sv
// datapath: event latch, rate state, shared divider and output word register
// depends on sfrm_pkg, sfrm_div and the assertion macro header
`include "smoothed_frame_rate_meter_top_defines.svh"

module sfrm_dp
  import sfrm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [TICK_W-1:0]  tick_rate,
  input  logic [RATE_W-1:0]  initial_rate,
  input  logic               in_mode,
  input  logic [STAMP_W-1:0] in_stamp,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata
);

  logic               ev_mode;
  logic [STAMP_W-1:0] ev_stamp;
  logic [STAMP_W-1:0] last_stamp;
  logic [RATE_W-1:0]  rate_avg;
  logic [SECS_W-1:0]  period_secs;
  logic [STAMP_W-1:0] period_ticks;

  logic [RATE_W-1:0]  init_clamped;
  logic [RATE_W+2:0]  blend_sum;
  logic [RATE_W-1:0]  blend_val;
  logic [RATE_W-1:0]  blend_clamped;

  logic [NUM_W-1:0]   div_num;
  logic [STAMP_W-1:0] div_den;
  logic               div_busy;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;

  assign init_clamped  = (initial_rate < ONE_Q16) ? ONE_Q16 : initial_rate;
  assign blend_sum     = {2'b00, rate_avg, 1'b0} + {3'b000, rate_avg} + {2'b00, div_quot};
  assign blend_val     = blend_sum[RATE_W+1:2];
  assign blend_clamped = (blend_val < ONE_Q16) ? ONE_Q16 : blend_val;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_TICKS: begin
        div_num = {(NUM_W-TICK_W)'(0), tick_rate};
        div_den = {(STAMP_W-TICK_W)'(0), rate_avg[RATE_W-1:16]};
      end
      DIV_INST: begin
        div_num = {1'b0, tick_rate, 16'h0000};
        div_den = period_ticks;
      end
      default: begin
        div_num = RECIP_NUM;
        div_den = {(STAMP_W-RATE_W)'(0), rate_avg};
      end
    endcase
  end

  sfrm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_mode  <= in_mode;
      ev_stamp <= in_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp   <= '0;
      rate_avg     <= INITIAL_RATE_RESET;
      period_secs  <= '0;
      period_ticks <= '0;
    end else begin
      if (cmd.load_start) begin
        rate_avg   <= init_clamped;
        last_stamp <= ev_stamp;
      end
      if (cmd.store_delta) begin
        period_ticks <= ev_stamp - last_stamp;
        last_stamp   <= ev_stamp;
      end
      if (cmd.store_ticks) begin
        period_ticks <= {(STAMP_W-NUM_W)'(0), div_quot};
      end
      if (cmd.blend) begin
        rate_avg <= blend_clamped;
      end
      if (cmd.store_secs) begin
        period_secs <= div_quot[SECS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {(OUT_W-RATE_W-SECS_W-STAMP_W)'(0), period_ticks, period_secs, rate_avg};
    end
  end

  assign status.mode       = ev_mode;
  assign status.same_stamp = (ev_stamp == last_stamp);
  assign status.div_done   = div_done;
  assign status.out_free   = !m_tvalid || m_tready;

  `SFRM_ASSERT_SAME(a_div_go_idle, cmd.div_go, !div_busy)
  `SFRM_ASSERT_NEXT(a_blend_floor, cmd.blend, rate_avg >= ONE_Q16)
  `SFRM_ASSERT_NEXT(a_start_floor, cmd.load_start, rate_avg >= ONE_Q16)
  `SFRM_ASSERT_SAME(a_emit_free, cmd.emit, !div_busy && (!m_tvalid || m_tready))

endmodule

### hdl/sfrm_ctrl.sv
// controller state machine sequencing event decode, divisions and output
// depends on sfrm_pkg
module sfrm_ctrl
  import sfrm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_RECIP;
    s_tready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (status.mode == MODE_START) begin
          cmd.load_start = 1'b1;
          state_next     = ST_TICKS_GO;
        end else if (status.same_stamp) begin
          state_next = ST_DONE;
        end else begin
          cmd.store_delta = 1'b1;
          state_next      = ST_INST_GO;
        end
      end
      ST_TICKS_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_TICKS;
        state_next  = ST_TICKS_WAIT;
      end
      ST_TICKS_WAIT: begin
        cmd.div_sel = DIV_TICKS;
        if (status.div_done) begin
          cmd.store_ticks = 1'b1;
          state_next      = ST_RECIP_GO;
        end
      end
      ST_INST_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_INST;
        state_next  = ST_INST_WAIT;
      end
      ST_INST_WAIT: begin
        cmd.div_sel = DIV_INST;
        if (status.div_done) begin
          cmd.blend  = 1'b1;
          state_next = ST_RECIP_GO;
        end
      end
      ST_RECIP_GO: begin
        cmd.div_go = 1'b1;
        state_next = ST_RECIP_WAIT;
      end
      ST_RECIP_WAIT: begin
        if (status.div_done) begin
          cmd.store_secs = 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/smoothed_frame_rate_meter_top.sv
// Smoothed frame rate meter. Each input word is an event stamped with a 64-bit
// tick count (tuser 0 start, 1 frame) and yields exactly one output word with
// the smoothed rate (Q32.16), seconds per frame (Q1.32) and the last frame
// period in ticks. One event is in flight at a time. A start event or a frame
// event with a new timestamp loads its output word after the decode state, two
// passes of the shared bit-serial divider (a launch and a wait state each) and
// the output state; the next event is accepted once the controller is back in
// idle. A frame event with an unchanged timestamp goes from decode straight to
// the output state. The output word register lets the next event be accepted
// while a result still waits; a result that is still waiting when the next one
// is ready holds the meter until it is taken. Registers are at byte address 0
// (tick_rate) and 8 (initial_rate); the user must write them only while the
// meter is idle, as the meter itself does not enforce this.
// depends on sfrm_pkg, sfrm_ctrl, sfrm_dp
module smoothed_frame_rate_meter_top
  import sfrm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [STAMP_W-1:0] s_tdata,   // timestamp
  input  logic               s_tuser,   // mode
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // frame_rate, frame_seconds, frame_ticks, zero pad
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  logic [TICK_W-1:0] tick_rate;
  logic [RATE_W-1:0] initial_rate;
  logic              cfg_wr;
  cmd_t              cmd;
  status_t           status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate    <= TICK_RATE_RESET;
      initial_rate <= INITIAL_RATE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_TICK_RATE:    tick_rate    <= pwdata[TICK_W-1:0];
        REG_INITIAL_RATE: initial_rate <= pwdata[RATE_W-1:0];
        default:          tick_rate    <= tick_rate;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_TICK_RATE:    prdata = {(CFG_W-TICK_W)'(0), tick_rate};
      REG_INITIAL_RATE: prdata = {(CFG_W-RATE_W)'(0), initial_rate};
      default:          prdata = '0;
    endcase
  end

  sfrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sfrm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .tick_rate    (tick_rate),
    .initial_rate (initial_rate),
    .in_mode      (s_tuser),
    .in_stamp     (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

### bench/tb_top.sv
// self-checking bench for the smoothed frame rate meter: directed and random events,
// random idling on both stream sides, register writes between phases
// depends on sfrm_pkg and smoothed_frame_rate_meter_top
module tb_top;
  import sfrm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned EVENTS_PER_PHASE = 190;
  localparam logic [ADDR_W-1:0] ADDR_TICK_RATE = {REG_TICK_RATE, 3'b000};
  localparam logic [ADDR_W-1:0] ADDR_INITIAL_RATE = {REG_INITIAL_RATE, 3'b000};
  localparam logic MODE_FRAME = ~MODE_START;
  localparam logic [63:0] ONE_RATE = 64'(ONE_Q16);

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic               mode;
    logic [STAMP_W-1:0] stamp;
  } meter_evt_t;

  typedef struct {
    logic [RATE_W-1:0]  rate;
    logic [SECS_W-1:0]  secs;
    logic [STAMP_W-1:0] ticks;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [STAMP_W-1:0] s_tdata = '0;  // timestamp
  logic               s_tuser = 1'b0;  // mode
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;  // frame_rate, frame_seconds, frame_ticks, zero pad
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [CFG_W-1:0]   pwdata = '0;
  logic [CFG_W-1:0]   prdata;
  logic               pready;

  smoothed_frame_rate_meter_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  meter_evt_t pending_evts[$];
  reading_t   expected_readings[$];
  idle_mode_t idle_mode = IDLE_NONE;
  int unsigned issued_n = 0;
  int unsigned accepted_n = 0;
  int unsigned err_count = 0;
  int unsigned cycle_n = 0;

  // predictor state and configuration
  logic [TICK_W-1:0]  cfg_ticks_per_sec = TICK_RATE_RESET;
  logic [RATE_W-1:0]  cfg_start_rate = INITIAL_RATE_RESET;
  logic [STAMP_W-1:0] prev_stamp = '0;
  logic [RATE_W-1:0]  smooth_rate = INITIAL_RATE_RESET;
  logic [SECS_W-1:0]  cur_secs = '0;
  logic [STAMP_W-1:0] cur_ticks = '0;

  function automatic logic [SECS_W-1:0] secs_for(input logic [63:0] rate);
    logic [63:0] r;
    r = (rate < ONE_RATE) ? ONE_RATE : rate;
    return SECS_W'((64'd1 << 48) / r);
  endfunction

  function automatic reading_t meter_advance(input logic mode, input logic [63:0] stamp);
    logic [63:0] start_rate;
    logic [63:0] delta;
    logic [63:0] inst;
    logic [63:0] blend;
    reading_t r;
    if (mode == MODE_START) begin
      start_rate = {16'd0, cfg_start_rate};
      if (start_rate < ONE_RATE) start_rate = ONE_RATE;
      smooth_rate = start_rate[RATE_W-1:0];
      cur_secs = secs_for(start_rate);
      cur_ticks = {32'd0, cfg_ticks_per_sec} / (start_rate >> 16);
      prev_stamp = stamp;
    end else if (stamp != prev_stamp) begin
      delta = stamp - prev_stamp;
      inst = ({32'd0, cfg_ticks_per_sec} << 16) / delta;
      blend = (64'd3 * {16'd0, smooth_rate} + inst) >> 2;
      if (blend < ONE_RATE) blend = ONE_RATE;
      cur_ticks = delta;
      prev_stamp = stamp;
      smooth_rate = blend[RATE_W-1:0];
      cur_secs = secs_for(blend);
    end
    r.rate = smooth_rate;
    r.secs = cur_secs;
    r.ticks = cur_ticks;
    return r;
  endfunction

  // driver: presents pending events, predicts on acceptance
  int unsigned gap_left = 0;
  always @(posedge clk) begin : driver
    bit hold;
    int unsigned pct;
    meter_evt_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_readings.push_back(meter_advance(s_tuser, s_tdata));
        accepted_n++;
      end
      if (!s_tvalid || s_tready) begin
        pct = (idle_mode == IDLE_SEND) ? 51 : (idle_mode == IDLE_BOTH) ? 7 : 0;
        hold = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          hold = 1'b1;
        end else if (pct > 0) begin
          hold = $urandom_range(0, 99) < pct;
          if ($urandom_range(0, 299) == 0) gap_left = $urandom_range(1, 200);
        end
        if (pending_evts.size() > 0 && !hold) begin
          ev = pending_evts.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= ev.mode;
          s_tdata <= ev.stamp;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  int unsigned stall_left = 0;
  always @(posedge clk) begin : receiver
    int unsigned pct;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      pct = (idle_mode == IDLE_RECV) ? 51 : (idle_mode == IDLE_BOTH) ? 7 : 0;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (pct > 0) begin
        m_tready <= $urandom_range(0, 99) >= pct;
        if ($urandom_range(0, 199) == 0) stall_left = $urandom_range(50, 300);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    err_count++;
    $display("%0t %s mismatch: expected %h actual %h", $time, field, want, got);
  endtask

  // monitor: compares each output word with the oldest expected reading
  always @(posedge clk) begin : monitor
    reading_t want;
    logic [RATE_W-1:0]  got_rate;
    logic [SECS_W-1:0]  got_secs;
    logic [STAMP_W-1:0] got_ticks;
    if (!rst && m_tvalid && m_tready) begin
      got_rate = m_tdata[RATE_W-1:0];
      got_secs = m_tdata[RATE_W +: SECS_W];
      got_ticks = m_tdata[RATE_W+SECS_W +: STAMP_W];
      if (expected_readings.size() == 0) begin
        err_count++;
        $display("%0t unexpected word: expected none actual %h", $time, m_tdata);
      end else begin
        want = expected_readings.pop_front();
        if (got_rate !== want.rate) report("frame_rate", 64'(want.rate), 64'(got_rate));
        if (got_secs !== want.secs) report("frame_seconds", 64'(want.secs), 64'(got_secs));
        if (got_ticks !== want.ticks) report("frame_ticks", want.ticks, got_ticks);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words outstanding", $time, expected_readings.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_TICK_RATE) cfg_ticks_per_sec = val[TICK_W-1:0];
    else cfg_start_rate = val[RATE_W-1:0];
  endtask

  task automatic set_rates(input logic [TICK_W-1:0] ticks, input logic [RATE_W-1:0] rate);
    reg_write(ADDR_TICK_RATE, {$urandom, ticks});
    reg_write(ADDR_INITIAL_RATE, {16'($urandom), rate});
  endtask

  task automatic push_evt(input logic mode, input logic [63:0] stamp);
    meter_evt_t ev;
    ev.mode = mode;
    ev.stamp = stamp;
    pending_evts.push_back(ev);
    issued_n++;
  endtask

  task automatic drain();
    while (pending_evts.size() != 0 || accepted_n != issued_n || expected_readings.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly start-then-frames runs paced near the nominal period, plus noise
  task automatic random_run(input int unsigned n);
    logic [63:0] stamp;
    logic [63:0] nominal;
    logic [63:0] rate_int;
    int unsigned pick;
    rate_int = {16'd0, cfg_start_rate} >> 16;
    nominal = {32'd0, cfg_ticks_per_sec} / ((rate_int == 0) ? 64'd1 : rate_int);
    if (nominal == 0) nominal = 1;
    stamp = {$urandom, $urandom};
    push_evt(MODE_START, stamp);
    for (int unsigned i = 1; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        stamp = ($urandom_range(0, 2) == 0)
                ? 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000))
                : {$urandom, $urandom};
        push_evt(MODE_START, stamp);
      end else if (pick < 10) begin
        stamp = {$urandom, $urandom};
        push_evt(MODE_FRAME, stamp);
      end else if (pick < 18) begin
        push_evt(MODE_FRAME, stamp);
      end else if (pick < 26) begin
        stamp = stamp + 64'($urandom_range(1, 64));
        push_evt(MODE_FRAME, stamp);
      end else if (pick < 30) begin
        stamp = stamp + {$urandom, $urandom};
        push_evt(MODE_FRAME, stamp);
      end else begin
        stamp = stamp + nominal - nominal / 8
                + (nominal / 4) * 64'($urandom_range(0, 100)) / 100
                + 64'($urandom_range(0, 1));
        push_evt(MODE_FRAME, stamp);
      end
    end
  endtask

  initial begin : stimulus
    logic [TICK_W-1:0] ticks;
    logic [RATE_W-1:0] rate;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: unchanged stamp before any start, wrap, delta of one
    push_evt(MODE_FRAME, 64'd0);
    push_evt(MODE_FRAME, 64'd17);
    push_evt(MODE_FRAME, 64'd34);
    push_evt(MODE_FRAME, 64'd34);
    push_evt(MODE_START, 64'd100);
    push_evt(MODE_FRAME, 64'd116);
    push_evt(MODE_FRAME, 64'd117);
    push_evt(MODE_FRAME, 64'd116);
    push_evt(MODE_START, 64'hFFFF_FFFF_FFFF_FFF0);
    push_evt(MODE_FRAME, 64'h0000_0000_0000_0001);
    push_evt(MODE_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    // largest settings
    set_rates(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_evt(MODE_START, 64'hAAAA_AAAA_AAAA_AAAA);
    push_evt(MODE_FRAME, 64'hAAAA_AAAA_AAAA_AAAB);
    push_evt(MODE_FRAME, 64'hAAAA_AAAA_AAAA_AAAB);
    push_evt(MODE_FRAME, 64'h2AAA_AAAA_AAAA_AAAB);
    push_evt(MODE_FRAME, 64'h5555_5555_5555_5555);
    drain();

    // zero tick rate and initial rate below one
    set_rates(32'd0, 48'd0);
    push_evt(MODE_START, 64'd5);
    push_evt(MODE_FRAME, 64'd6);
    push_evt(MODE_FRAME, 64'd1000);
    push_evt(MODE_FRAME, 64'd1000);
    drain();

    set_rates(32'd1, 48'd65535);
    push_evt(MODE_START, 64'd0);
    push_evt(MODE_FRAME, 64'd1);
    push_evt(MODE_FRAME, 64'd3);
    drain();

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: ticks = $urandom_range(1, 1000);
        1: ticks = $urandom_range(1000, 1000000);
        2: ticks = $urandom;
        default: ticks = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 4))
        0, 1: rate = RATE_W'($urandom_range(1, 240)) * 65536
                     + RATE_W'($urandom_range(0, 65535));
        2: rate = {16'($urandom), $urandom};
        3: rate = RATE_W'($urandom_range(0, 65536));
        default: rate = 48'hFFFF_FFFF_FFFF;
      endcase
      set_rates(ticks, rate);
      idle_mode = idle_mode_t'(ph % 4);
      random_run(EVENTS_PER_PHASE);
      drain();
      idle_mode = IDLE_NONE;
    end

    repeat (120) @(posedge clk);
    if (err_count == 0 && expected_readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
